// ===== rtl/core/sfc_pkg.sv =====
// sfc_pkg: shared constants, register codes and stage-advance type for the
// sphere frustum cull pipeline. No dependencies.
package sfc_pkg;

  // default coordinate width (signed Q12.8 centers, unsigned Q12.8 radius)
  localparam int COORD_WIDTH_DEF = 20;

  // axis components are signed Q1.18
  localparam int DIR_WIDTH = 20;
  localparam int AXIS_WIDTH = 3 * DIR_WIDTH;

  // cone slopes and reciprocal radius factors are unsigned Q8.16
  localparam int SLOPE_WIDTH = 24;
  localparam int PAIR_WIDTH = 2 * SLOPE_WIDTH;

  // near and far limits, unsigned Q12.8
  localparam int LIMIT_WIDTH = 20;
  localparam logic [LIMIT_WIDTH-1:0] FAR_RESET = '1;

  // configuration port
  localparam int CFG_WIDTH = 60;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EYE_POSITION   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FORWARD_AXIS   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RIGHT_AXIS     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_AXIS        = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NEAR_LIMIT     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAR_LIMIT      = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONE_SLOPES    = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_FACTORS = 3'd7;

  // fixed-point alignment shifts
  localparam int DEPTH_SHIFT  = 18;  // Q.8 distance to Q.26 depth
  localparam int DIST_SHIFT   = 18;  // Q.24 radius term to Q.42
  localparam int OFFSET_SHIFT = 16;  // Q.26 offset to Q.42

  // low part of the depth operand in the split depth * slope product
  localparam int DEPTH_SPLIT = 27;

  // advance enables of the lateral test stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } sfc_adv_t;

endpackage

// ===== rtl/core/sfc_lateral.sv =====
// sfc_lateral: four-stage lateral cone test, |offset| <= depth*slope + r/factor.
// Depends on sfc_pkg. Stages advance on the enables handed in by the top level.
module sfc_lateral #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  sfc_pkg::sfc_adv_t                      adv,
  input  logic signed [COORD_WIDTH+21:0]         depth,    // Q.26
  input  logic signed [COORD_WIDTH+21:0]         offset,   // Q.26
  input  logic        [sfc_pkg::SLOPE_WIDTH-1:0] slope,    // Q8.16
  input  logic [COORD_WIDTH+sfc_pkg::SLOPE_WIDTH-1:0] rad_inv,  // Q.24
  output logic                                   in_cone
);
  import sfc_pkg::*;

  localparam int DW  = COORD_WIDTH + 22;
  localparam int HW  = DW - DEPTH_SPLIT;
  localparam int AW  = DW + SLOPE_WIDTH;
  localparam int RIW = COORD_WIDTH + SLOPE_WIDTH;
  localparam int BW  = COORD_WIDTH + 50;

  // stage 4: partial products of depth * slope
  logic signed [HW+SLOPE_WIDTH-1:0]        hi_prod;
  logic        [DEPTH_SPLIT+SLOPE_WIDTH-1:0] lo_prod;
  logic signed [DW-1:0]                    p4;
  logic        [RIW-1:0]                   dist4;

  // stage 5: full cone term
  logic signed [AW-1:0] aux5;
  logic signed [AW-1:0] hi_ext;
  logic signed [AW-1:0] lo_ext;
  logic signed [DW-1:0] p5;
  logic        [RIW-1:0] dist5;

  // stage 6: bound and aligned offset
  logic signed [BW-1:0] bound6;
  logic signed [BW-1:0] pw6;

  // stage 7 compare
  logic signed [BW-1:0] above;
  logic signed [BW-1:0] below;

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      hi_prod <= $signed(depth[DW-1:DEPTH_SPLIT]) * $signed({1'b0, slope});
      lo_prod <= depth[DEPTH_SPLIT-1:0] * slope;
      p4      <= offset;
      dist4   <= rad_inv;
    end
  end

  assign hi_ext = AW'(hi_prod);
  assign lo_ext = AW'($signed({1'b0, lo_prod}));

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      aux5  <= (hi_ext <<< DEPTH_SPLIT) + lo_ext;
      p5    <= p4;
      dist5 <= dist4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s6) begin
      bound6 <= BW'(aux5) + BW'($signed({1'b0, dist5, {DIST_SHIFT{1'b0}}}));
      pw6    <= BW'($signed({p5, {OFFSET_SHIFT{1'b0}}}));
    end
  end

  // strict: reject when bound < offset or offset < -bound
  assign above = bound6 - pw6;
  assign below = bound6 + pw6;

  always_ff @(posedge clk) begin
    if (adv.s7) begin
      in_cone <= !above[BW-1] && !below[BW-1];
    end
  end

endmodule

// ===== rtl/core/sphere_frustum_cull.sv =====
// sphere_frustum_cull: top level of the radar-method sphere/frustum test.
// Depends on sfc_pkg and sfc_lateral (one instance per lateral axis).
//
// Each request carries a sphere center and radius; the block answers with one
// result whose bit 0 is set when the sphere may lie inside the view frustum.
// It is a seven-stage pipeline that takes one sphere per clock while the
// output side keeps up. Stage depth is set by the nine center-offset times
// axis multipliers (dot products for forward, up and right) and by the
// depth-times-slope product, which is split into two partial products and
// merged a stage later. Stalls on the output back up stage by stage; an empty
// stage still moves, so bubbles are squeezed out and the input side is ready
// whenever the pipe has room. Camera registers are written through the plain
// write port; the user must write them only while no request is in flight, as
// the block does not enforce it. The tests compare strictly against near - r,
// far + r and the cone half-widths depth*tan + r/factor.
module sphere_frustum_cull #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // request: center_x, center_y, center_z, sphere_radius (lowest bit up)
  input  logic [8*((4*COORD_WIDTH+7)/8)-1:0]    s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // result: visible, then zero fill
  output logic [7:0]                            m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [sfc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [sfc_pkg::CFG_WIDTH-1:0]         cfg_data
);
  import sfc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 22;          // dot product width, Q.26
  localparam int PW   = CW + 21;          // single product width
  localparam int RIW  = CW + SLOPE_WIDTH; // radius * reciprocal factor, Q.24
  localparam int RW   = ((CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH) + 1;
  localparam int CMPW = CW + 44;
  localparam int NSTG = 7;

  // camera registers
  logic [CFG_WIDTH-1:0]   eye_position;
  logic [AXIS_WIDTH-1:0]  forward_axis;
  logic [AXIS_WIDTH-1:0]  right_axis;
  logic [AXIS_WIDTH-1:0]  up_axis;
  logic [LIMIT_WIDTH-1:0] near_limit;
  logic [LIMIT_WIDTH-1:0] far_limit;
  logic [PAIR_WIDTH-1:0]  cone_slopes;
  logic [PAIR_WIDTH-1:0]  radius_factors;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_position   <= '0;
      forward_axis   <= '0;
      right_axis     <= '0;
      up_axis        <= '0;
      near_limit     <= '0;
      far_limit      <= FAR_RESET;
      cone_slopes    <= '0;
      radius_factors <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EYE_POSITION:   eye_position   <= cfg_data;
        REG_FORWARD_AXIS:   forward_axis   <= cfg_data[AXIS_WIDTH-1:0];
        REG_RIGHT_AXIS:     right_axis     <= cfg_data[AXIS_WIDTH-1:0];
        REG_UP_AXIS:        up_axis        <= cfg_data[AXIS_WIDTH-1:0];
        REG_NEAR_LIMIT:     near_limit     <= cfg_data[LIMIT_WIDTH-1:0];
        REG_FAR_LIMIT:      far_limit      <= cfg_data[LIMIT_WIDTH-1:0];
        REG_CONE_SLOPES:    cone_slopes    <= cfg_data[PAIR_WIDTH-1:0];
        REG_RADIUS_FACTORS: radius_factors <= cfg_data[PAIR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // eye fields are CW wide; fields past the register read as zero
  logic [3*CW-1:0] eye_ext;
  assign eye_ext = (3*CW)'(eye_position);

  // stage valid bits and advance enables
  logic [NSTG:1] v;
  logic [NSTG:1] en;

  // enables are resolved from the output stage back to the input
  always_comb begin
    en[NSTG] = !v[NSTG] || m_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // request fields
  logic signed [CW-1:0] center [3];
  logic        [CW-1:0] sphere_radius;

  assign center[0]     = $signed(s_tdata[CW-1:0]);
  assign center[1]     = $signed(s_tdata[2*CW-1:CW]);
  assign center[2]     = $signed(s_tdata[3*CW-1:2*CW]);
  assign sphere_radius = s_tdata[4*CW-1:3*CW];

  // stage 1: offset from the eye
  logic signed [CW:0]   d1 [3];
  logic        [CW-1:0] rad1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= (CW+1)'(center[i]) - (CW+1)'($signed(eye_ext[i*CW +: CW]));
      end
      rad1 <= sphere_radius;
    end
  end

  // stage 2: per-component products and radius terms
  logic signed [PW-1:0] pf [3];
  logic signed [PW-1:0] pu [3];
  logic signed [PW-1:0] pr [3];
  logic        [CW-1:0] rad2;
  logic        [RIW-1:0] rinv_y2;
  logic        [RIW-1:0] rinv_x2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        pf[i] <= d1[i] * $signed(forward_axis[i*DIR_WIDTH +: DIR_WIDTH]);
        pu[i] <= d1[i] * $signed(up_axis[i*DIR_WIDTH +: DIR_WIDTH]);
        pr[i] <= d1[i] * $signed(right_axis[i*DIR_WIDTH +: DIR_WIDTH]);
      end
      rad2    <= rad1;
      rinv_y2 <= rad1 * radius_factors[SLOPE_WIDTH-1:0];
      rinv_x2 <= rad1 * radius_factors[PAIR_WIDTH-1:SLOPE_WIDTH];
    end
  end

  // stage 3: dot products and depth window
  logic        [RW-1:0]   far_sum;
  logic signed [RW:0]     near_diff;
  logic signed [DW-1:0]   pz3;
  logic signed [DW-1:0]   py3;
  logic signed [DW-1:0]   px3;
  logic signed [CMPW-1:0] far_b3;
  logic signed [CMPW-1:0] near_b3;
  logic        [RIW-1:0]  rinv_y3;
  logic        [RIW-1:0]  rinv_x3;

  assign far_sum   = RW'(far_limit) + RW'(rad2);
  assign near_diff = $signed((RW+1)'(near_limit) - (RW+1)'(rad2));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pz3     <= DW'(pf[0]) + DW'(pf[1]) + DW'(pf[2]);
      py3     <= DW'(pu[0]) + DW'(pu[1]) + DW'(pu[2]);
      px3     <= DW'(pr[0]) + DW'(pr[1]) + DW'(pr[2]);
      far_b3  <= CMPW'($signed({1'b0, far_sum, {DEPTH_SHIFT{1'b0}}}));
      near_b3 <= CMPW'($signed({near_diff, {DEPTH_SHIFT{1'b0}}}));
      rinv_y3 <= rinv_y2;
      rinv_x3 <= rinv_x2;
    end
  end

  // stages 4..7: depth verdict rides along with the lateral tests
  logic signed [CMPW-1:0] pz_cmp;
  logic                   depth_ok4;
  logic                   depth_ok5;
  logic                   depth_ok6;
  logic                   depth_ok7;

  assign pz_cmp = CMPW'(pz3);

  always_ff @(posedge clk) begin
    if (en[4]) depth_ok4 <= !(pz_cmp > far_b3 || pz_cmp < near_b3);
    if (en[5]) depth_ok5 <= depth_ok4;
    if (en[6]) depth_ok6 <= depth_ok5;
    if (en[7]) depth_ok7 <= depth_ok6;
  end

  sfc_adv_t adv;
  assign adv = '{s4: en[4], s5: en[5], s6: en[6], s7: en[7]};

  logic ok_y7;
  logic ok_x7;

  sfc_lateral #(.COORD_WIDTH(COORD_WIDTH)) u_lat_y (
    .clk     (clk),
    .adv     (adv),
    .depth   (pz3),
    .offset  (py3),
    .slope   (cone_slopes[SLOPE_WIDTH-1:0]),
    .rad_inv (rinv_y3),
    .in_cone (ok_y7)
  );

  sfc_lateral #(.COORD_WIDTH(COORD_WIDTH)) u_lat_x (
    .clk     (clk),
    .adv     (adv),
    .depth   (pz3),
    .offset  (px3),
    .slope   (cone_slopes[PAIR_WIDTH-1:SLOPE_WIDTH]),
    .rad_inv (rinv_x3),
    .in_cone (ok_x7)
  );

  // result
  assign m_tvalid = v[NSTG];
  assign m_tdata  = {7'b0, depth_ok7 && ok_y7 && ok_x7};

  // an accepted request always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[1])
    else $error("accepted request lost at stage 1");

  // an empty output stage means the whole pipe can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NSTG] |-> s_tready)
    else $error("input stalled with output stage empty");

  // a taken result with nothing behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !v[NSTG-1]) |=> !m_tvalid)
    else $error("result repeated after being taken");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

// ===== test/sphere_frustum_cull_tb.sv =====
// sphere_frustum_cull_tb: self-checking testbench for the sphere/frustum cull block.
// Depends on sfc_pkg and the sphere_frustum_cull RTL; a scoreboard class predicts
// each visible bit from its own copy of the camera registers.
module sphere_frustum_cull_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DW = 8 * ((4 * CW + 7) / 8);
  // a unit axis component in Q1.18
  localparam int UNIT = 1 << 18;

  // predicts the visible bit of every accepted sphere and checks results in order
  class cull_scoreboard;
    logic [CFG_WIDTH-1:0] regs [8];
    bit pending_vis [$];
    int mismatches;
    int results_seen;
    int visible_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_FAR_LIMIT] = CFG_WIDTH'(FAR_RESET);
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] v);
      regs[idx] = v;
    endfunction

    function int pending();
      return pending_vis.size();
    endfunction

    // signed field i of a packed register
    function longint field_of(logic [CFG_WIDTH-1:0] r, int i, int w);
      logic [CFG_WIDTH-1:0] s;
      s = r >> (i * w);
      return (longint'(s) << (64 - w)) >>> (64 - w);
    endfunction

    // offset . axis, exact in Q.26
    function longint project(longint d [3], logic [CFG_WIDTH-1:0] axis);
      return d[0] * field_of(axis, 0, DIR_WIDTH) + d[1] * field_of(axis, 1, DIR_WIDTH)
           + d[2] * field_of(axis, 2, DIR_WIDTH);
    endfunction

    // strict test of p against +/-(depth*slope + r*inv), everything in Q.42
    function bit within_cone(longint p, longint depth, logic [SLOPE_WIDTH-1:0] slope,
                             logic [CW-1:0] rad, logic [SLOPE_WIDTH-1:0] inv);
      logic signed [127:0] pw, spread, rterm, bound;
      pw = p;
      pw = pw <<< 16;
      spread = depth;
      spread = spread * $signed({104'd0, slope});
      rterm = $signed({{(128 - CW){1'b0}}, rad}) * $signed({104'd0, inv});
      rterm = rterm <<< 18;
      bound = spread + rterm;
      return !(bound < pw) && !(pw < -bound);
    endfunction

    function bit predict(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                         logic [CW-1:0] rad);
      longint d [3];
      longint depth, far_edge, near_edge;
      logic [CW-1:0] c [3];
      c[0] = cx;
      c[1] = cy;
      c[2] = cz;
      for (int i = 0; i < 3; i++)
        d[i] = longint'($signed(c[i])) - field_of(regs[REG_EYE_POSITION], i, CW);
      depth = project(d, regs[REG_FORWARD_AXIS]);
      far_edge = (longint'(regs[REG_FAR_LIMIT][LIMIT_WIDTH-1:0]) + longint'(rad)) <<< 18;
      near_edge = (longint'(regs[REG_NEAR_LIMIT][LIMIT_WIDTH-1:0]) - longint'(rad)) * UNIT;
      if (depth > far_edge || depth < near_edge)
        return 1'b0;
      if (!within_cone(project(d, regs[REG_UP_AXIS]), depth,
                       regs[REG_CONE_SLOPES][SLOPE_WIDTH-1:0], rad,
                       regs[REG_RADIUS_FACTORS][SLOPE_WIDTH-1:0]))
        return 1'b0;
      return within_cone(project(d, regs[REG_RIGHT_AXIS]), depth,
                         regs[REG_CONE_SLOPES][PAIR_WIDTH-1:SLOPE_WIDTH], rad,
                         regs[REG_RADIUS_FACTORS][PAIR_WIDTH-1:SLOPE_WIDTH]);
    endfunction

    function void note_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                              logic [CW-1:0] rad);
      pending_vis.push_back(predict(cx, cy, cz, rad));
    endfunction

    function void check_result(logic vis);
      bit want;
      results_seen++;
      if (pending_vis.size() == 0) begin
        $error("visible: no request pending, got %0b", vis);
        mismatches++;
        return;
      end
      want = pending_vis.pop_front();
      visible_seen += want;
      if (vis !== want) begin
        $error("visible: expected %0b, got %0b", want, vis);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [DW-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  cull_scoreboard sb = new();

  // idle switches, flipped per phase so some stretches run back to back
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int stall_left = 0;
  int cameras = 0;

  // placement state of the current axis-aligned camera: which world axis carries
  // forward, up and right, with a sign, plus eye and cone parameters
  int fwd_ax, up_ax, rgt_ax;
  bit fwd_neg, up_neg, rgt_neg;
  longint eye_c [3];
  longint near_q, far_q, tan_y, tan_x, inv_y, inv_x;

  sphere_frustum_cull #(.COORD_WIDTH(CW)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint jitter(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // cone half-width in Q.8 for the axis-aligned camera (floor of the exact bound)
  function automatic longint cone_edge(longint dep, longint rad, bit horiz);
    return (dep * (horiz ? tan_x : tan_y) + rad * (horiz ? inv_x : inv_y)) >>> 16;
  endfunction

  // lateral offset: either hugging the cone wall or spread a bit past it
  function automatic longint lateral_pick(longint e);
    longint a;
    a = (e < 0) ? -e : e;
    if ($urandom_range(0, 2) == 0)
      return ($urandom_range(0, 1) ? a : -a) + jitter(2);
    a = a + a / 4 + 1;
    return longint'($urandom_range(0, 32'(2 * a))) - a;
  endfunction

  function automatic logic [CFG_WIDTH-1:0] unit_axis(int ax, bit neg);
    logic [CFG_WIDTH-1:0] v;
    logic [DIR_WIDTH-1:0] u;
    u = UNIT[DIR_WIDTH-1:0];
    v = '0;
    v[ax * DIR_WIDTH +: DIR_WIDTH] = neg ? -u : u;
    return v;
  endfunction

  // result side: check each accepted result, then decide whether to stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[0]);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_idle && $urandom_range(0, 99) < 30)
        stall_left = idle_len();
    end
  end

  // writes all eight registers back to back; only called with the pipe empty
  task automatic load_camera(logic [CFG_WIDTH-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_INDEX_WIDTH-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(i[CFG_INDEX_WIDTH-1:0], vals[i]);
    end
    cfg_we <= 1'b0;
    cameras++;
  endtask

  // axis-aligned camera; perm picks the axis order, signs flips each axis
  task automatic aim_camera(longint ex, longint ey, longint ez, int perm, int signs,
                            longint nr, longint fr, longint ty, longint tx,
                            longint iy, longint ix);
    logic [CFG_WIDTH-1:0] vals [8];
    fwd_ax = perm % 3;
    up_ax = (fwd_ax + 1 + perm / 3) % 3;
    rgt_ax = 3 - fwd_ax - up_ax;
    fwd_neg = signs[0];
    up_neg = signs[1];
    rgt_neg = signs[2];
    eye_c[0] = ex;
    eye_c[1] = ey;
    eye_c[2] = ez;
    near_q = nr;
    far_q = fr;
    tan_y = ty;
    tan_x = tx;
    inv_y = iy;
    inv_x = ix;
    vals[REG_EYE_POSITION] = {ez[CW-1:0], ey[CW-1:0], ex[CW-1:0]};
    vals[REG_FORWARD_AXIS] = unit_axis(fwd_ax, fwd_neg);
    vals[REG_RIGHT_AXIS] = unit_axis(rgt_ax, rgt_neg);
    vals[REG_UP_AXIS] = unit_axis(up_ax, up_neg);
    vals[REG_NEAR_LIMIT] = CFG_WIDTH'(nr[LIMIT_WIDTH-1:0]);
    vals[REG_FAR_LIMIT] = CFG_WIDTH'(fr[LIMIT_WIDTH-1:0]);
    vals[REG_CONE_SLOPES] = CFG_WIDTH'({tx[SLOPE_WIDTH-1:0], ty[SLOPE_WIDTH-1:0]});
    vals[REG_RADIUS_FACTORS] = CFG_WIDTH'({ix[SLOPE_WIDTH-1:0], iy[SLOPE_WIDTH-1:0]});
    load_camera(vals);
  endtask

  // one request; valid stays high from one request to the next unless a gap is drawn
  task automatic send_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                             logic [CW-1:0] rad);
    int gap;
    gap = (tx_idle && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DW'({rad, cz, cy, cx});
    do @(posedge clk); while (!s_tready);
    sb.note_sphere(cx, cy, cz, rad);
  endtask

  // sphere given in camera coordinates (depth, vertical, horizontal), all Q.8
  task automatic send_view(longint dep, longint vert, longint horiz, longint rad);
    longint c [3];
    c = eye_c;
    c[fwd_ax] += fwd_neg ? -dep : dep;
    c[up_ax] += up_neg ? -vert : vert;
    c[rgt_ax] += rgt_neg ? -horiz : horiz;
    send_sphere(c[0][CW-1:0], c[1][CW-1:0], c[2][CW-1:0], rad[CW-1:0]);
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] vals [8];
    longint dep, rad, e;
    bit aligned;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: all axes zero, so every sphere passes
    send_sphere('0, '0, '0, '0);
    send_sphere({1'b1, {(CW-1){1'b0}}}, {(CW){1'b1}}, {1'b0, {(CW-1){1'b1}}}, '1);
    drain();

    // eye at (10, -5, 3), forward +x, up +y, right +z, near 1, far 100,
    // slopes and factors exact so the cone wall lands on whole Q.8 steps
    aim_camera(2560, -1280, 768, 0, 0, 256, 25600, 65536, 131072, 65536, 65536);
    send_view(12800, 0, 0, 0);
    // depth exactly on near - r passes, one step closer fails
    send_view(256 - 512, 0, 0, 512);
    send_view(256 - 512 - 1, 0, 0, 512);
    // depth exactly on far + r passes, one step farther fails
    send_view(25600 + 512, 0, 0, 512);
    send_view(25600 + 512 + 1, 0, 0, 512);
    // vertical wall: on the bound passes, beyond fails, both sides
    e = cone_edge(5000, 300, 1'b0);
    send_view(5000, e, 0, 300);
    send_view(5000, e + 1, 0, 300);
    send_view(5000, -e, 0, 300);
    send_view(5000, -e - 1, 0, 300);
    // horizontal wall, wider slope than vertical
    e = cone_edge(5000, 300, 1'b1);
    send_view(5000, 0, e, 300);
    send_view(5000, 0, e + 1, 300);
    send_view(5000, 0, -e - 1, 300);
    // largest radius at the eye, then coordinate extremes
    send_view(0, 0, 0, 64'hFFFFF);
    send_sphere({1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, '0);
    send_sphere({1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, '1);
    drain();

    // zero radius factors, near at zero: a sphere behind the eye gets a negative
    // cone bound and is always rejected even on the axis
    aim_camera(0, 0, 0, 4, 5, 0, 25600, 65536, 65536, 0, 0);
    send_view(-100, 0, 0, 200);
    send_view(100, 0, 0, 200);
    send_view(100, 100, 0, 200);
    send_view(100, 101, 0, 200);
    drain();

    // random phases, each with its own camera and idle pattern
    for (int phase = 0; phase < 10; phase++) begin
      aligned = 1'b0;
      if (phase % 5 == 2) begin
        // extreme cameras: every register all ones, then all zeros
        foreach (vals[i]) vals[i] = (phase == 2) ? '1 : '0;
        load_camera(vals);
      end else if (phase == 8) begin
        // unnormalized axes and arbitrary limits
        foreach (vals[i]) vals[i] = CFG_WIDTH'({$urandom, $urandom});
        load_camera(vals);
      end else begin
        aligned = 1'b1;
        aim_camera(longint'($urandom_range(0, 65535)) - 32768,
                   longint'($urandom_range(0, 65535)) - 32768,
                   longint'($urandom_range(0, 65535)) - 32768,
                   $urandom_range(0, 5), $urandom_range(0, 7),
                   $urandom_range(0, 1024), $urandom_range(4096, 65536),
                   $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(65536, 131072),
                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(65536, 131072));
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);

      for (int n = 0; n < 60; n++) begin
        if (aligned && $urandom_range(0, 9) < 8) begin
          rad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20'hFFFFF)
                                            : $urandom_range(0, 4096);
          case ($urandom_range(0, 3))
            0: dep = near_q - rad + jitter(2);
            1: dep = far_q + rad + jitter(2);
            default: dep = $urandom_range(32'(near_q), 32'(far_q));
          endcase
          send_view(dep, lateral_pick(cone_edge(dep, rad, 1'b0)),
                    lateral_pick(cone_edge(dep, rad, 1'b1)), rad);
        end else begin
          send_sphere(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
        end
        // once, hold the sender mid-phase until the pipe is empty
        if (phase == 4 && n == 30)
          drain();
      end
      drain();
    end

    $display("%0d results checked across %0d camera setups, %0d of them visible",
             sb.results_seen, cameras, sb.visible_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
